[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define MMRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MMRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mmrd_pkg.sv]
// Shared types, constants and the CRC step for the meter response decoder.
package mmrd_pkg;

  typedef enum logic [1:0] {
    ST_REJECT  = 2'd0,
    ST_REQUEST = 2'd1,
    ST_SUMMARY = 2'd2,
    ST_PHASE   = 2'd3
  } res_status_t;

  typedef enum logic [1:0] {
    PEND_NONE    = 2'd0,
    PEND_SUMMARY = 2'd1,
    PEND_PHASES  = 2'd2
  } pend_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_JUDGE,
    S_SINGLE,
    S_FETCH,
    S_CATCH,
    S_PUT
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic judge;
    logic seq_clr;
    logic fetch;
    logic load_single;
    logic load_value;
    logic val_next;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic multi;
    logic k_last;
    logic vi_last;
  } dp_stat_t;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FUNC_READ    = 8'd3;
  localparam logic [15:0] ADDR_SUMMARY = 16'h0102;
  localparam logic [15:0] ADDR_PHASE   = 16'h011E;
  localparam logic [15:0] CNT_SUMMARY  = 16'd16;
  localparam logic [15:0] CNT_PHASE    = 16'd42;
  localparam logic [7:0]  BC_SUMMARY   = 8'd32;
  localparam logic [7:0]  BC_PHASE     = 8'd84;
  localparam int          LEN_MIN      = 5;
  localparam int          LEN_REQ      = 8;
  localparam int          LEN_SUMMARY  = 37;
  localparam int          LEN_PHASE    = 89;
  localparam int          HDR_BYTES    = 6;
  localparam int          VAL_BASE     = 3;
  localparam logic [4:0]  LAST_SUMMARY = 5'd7;
  localparam logic [4:0]  LAST_PHASE   = 5'd20;

  // Modbus CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/mmrd_ctrl.sv]
// Sequencer: byte intake, frame verdict and per-value emission.
module mmrd_ctrl import mmrd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     frame_valid,
  input  logic     frame_end,
  output logic     frame_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    frame_stall = 1'b1;
    case (state)
      S_IDLE: begin
        frame_stall = 1'b0;
        if (frame_valid) begin
          cmd.take_byte = 1'b1;
          if (frame_end) state_next = S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd.judge   = 1'b1;
        cmd.seq_clr = 1'b1;
        state_next  = stat.multi ? S_FETCH : S_SINGLE;
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.k_last) state_next = S_CATCH;
      end
      // last of the four bytes lands in the shifter
      S_CATCH: state_next = S_PUT;
      S_PUT: begin
        if (stat.out_free) begin
          cmd.load_value = 1'b1;
          if (stat.vi_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.val_next = 1'b1;
            state_next   = S_FETCH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/mmrd_dp.sv]
// Datapath: frame buffer, CRC, header capture, verdict and result register.
module mmrd_dp import mmrd_pkg::*; #(
  parameter int MAX_FRAME = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic [7:0]         frame_byte,
  input  logic               frame_end,
  input  logic [31:0]        now_ms,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               result_stall,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic [4:0]         value_index,
  output logic signed [31:0] value,
  output logic [31:0]        measured_ms,
  output logic               last
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [7:0]    mem [MAX_FRAME];
  logic [7:0]    rd_data;
  logic          rd_pending;
  logic [CW-1:0] count;
  logic [15:0]   crc;
  logic          ovf;
  logic [7:0]    unit_id;
  pend_t         pend;
  logic [7:0]    hdr [HDR_BYTES];
  logic [31:0]   stamp;
  logic [31:0]   sh;
  logic [1:0]    k;
  logic [4:0]    vi;
  logic [4:0]    vi_max;
  res_status_t   res_code;
  logic [AW-1:0] rd_addr;
  logic          room;

  logic          bad, is_req, sum_ok, ph_ok;
  pend_t         req_kind;
  logic [15:0]   addr16, cnt16;

  assign room    = count < CW'(MAX_FRAME);
  assign rd_addr = AW'(VAL_BASE) + AW'({vi, 2'b00}) + AW'(k);
  assign addr16  = {hdr[2], hdr[3]};
  assign cnt16   = {hdr[4], hdr[5]};

  always_comb begin
    bad = ovf || (crc != 16'h0000) || (count < CW'(LEN_MIN)) ||
          (hdr[0] != unit_id) || (hdr[1] != FUNC_READ);
    is_req = count == CW'(LEN_REQ);
    if (addr16 == ADDR_SUMMARY && cnt16 == CNT_SUMMARY) begin
      req_kind = PEND_SUMMARY;
    end else if (addr16 == ADDR_PHASE && cnt16 == CNT_PHASE) begin
      req_kind = PEND_PHASES;
    end else begin
      req_kind = PEND_NONE;
    end
    sum_ok = pend == PEND_SUMMARY && count == CW'(LEN_SUMMARY) && hdr[2] == BC_SUMMARY;
    ph_ok  = pend == PEND_PHASES && count == CW'(LEN_PHASE) && hdr[2] == BC_PHASE;
  end

  assign stat.out_free = !result_valid || !result_stall;
  assign stat.multi    = !bad && !is_req && (sum_ok || ph_ok);
  assign stat.k_last   = k == 2'd3;
  assign stat.vi_last  = vi == vi_max;

  // frame buffer
  always_ff @(posedge clk) begin
    if (cmd.take_byte && room) mem[count[AW-1:0]] <= frame_byte;
    if (cmd.fetch) rd_data <= mem[rd_addr];
  end

  // header bytes and frame timestamp
  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (cmd.take_byte && count == CW'(i)) hdr[i] <= frame_byte;
    end
    if (cmd.take_byte && frame_end) stamp <= now_ms;
    if (rd_pending) sh <= {sh[23:0], rd_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      crc        <= CRC_INIT;
      ovf        <= 1'b0;
      pend       <= PEND_NONE;
      unit_id    <= 8'd1;
      rd_pending <= 1'b0;
      k          <= '0;
      vi         <= '0;
      vi_max     <= '0;
      res_code   <= ST_REJECT;
    end else begin
      rd_pending <= cmd.fetch;
      if (cfg_we) unit_id <= cfg_wdata;
      if (cmd.take_byte) begin
        crc <= crc16_byte(crc, frame_byte);
        if (room) count <= count + CW'(1);
        else      ovf   <= 1'b1;
      end
      if (cmd.judge) begin
        count <= '0;
        crc   <= CRC_INIT;
        ovf   <= 1'b0;
        if (bad) begin
          res_code <= ST_REJECT;
        end else if (is_req) begin
          pend     <= req_kind;
          res_code <= (req_kind != PEND_NONE) ? ST_REQUEST : ST_REJECT;
        end else begin
          pend     <= PEND_NONE;
          res_code <= sum_ok ? ST_SUMMARY : (ph_ok ? ST_PHASE : ST_REJECT);
          vi_max   <= sum_ok ? LAST_SUMMARY : LAST_PHASE;
        end
      end
      if (cmd.seq_clr) begin
        k  <= '0;
        vi <= '0;
      end
      if (cmd.fetch) k <= k + 2'd1;
      if (cmd.val_next) vi <= vi + 5'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_value) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      status      <= res_code;
      value_index <= '0;
      value       <= '0;
      measured_ms <= '0;
      last        <= 1'b1;
    end else if (cmd.load_value) begin
      status      <= res_code;
      value_index <= vi;
      value       <= {sh[15:0], sh[31:16]}; // low register first
      measured_ms <= stamp;
      last        <= vi == vi_max;
    end
  end

endmodule

[sv/modbus_meter_response_decoder.sv]
// Top level of the Modbus RTU meter response decoder.
//
//   channel   dir  handshake                  payload
//   frame     in   frame_valid / frame_stall  frame_byte, frame_end, now_ms
//   result    out  result_valid/result_stall  status, value_index, value,
//                                             measured_ms, last
//   config    in   cfg_we                     cfg_wdata (unit id)
//
// A byte without frame_end is taken while the sequencer is idle; the CRC step runs as it is taken.
// A frame end passes the verdict state, then loads a single result (reject or request).
// A decoded response passes one verdict state, then per value four buffer
// reads through the one read port, a catch state for the last read and a
// put state that loads the value.
// Result stalls hold the sequencer; frame_stall is high until the last
// result of a frame sits in the output register.
// rst is synchronous; it clears the frame, the pending request and sets
// the unit id to 1.
module modbus_meter_response_decoder import mmrd_pkg::*; #(
  parameter int MAX_FRAME = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic [7:0]         frame_byte,
  input  logic               frame_end,
  input  logic [31:0]        now_ms,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic [4:0]         value_index,
  output logic signed [31:0] value,
  output logic [31:0]        measured_ms,
  output logic               last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // state machine: intake, verdict, read/emit sequencing
  mmrd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_end   (frame_end),
    .frame_stall (frame_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // buffer, CRC, header checks, pending request, result register
  mmrd_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .frame_byte   (frame_byte),
    .frame_end    (frame_end),
    .now_ms       (now_ms),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .status       (status),
    .value_index  (value_index),
    .value        (value),
    .measured_ms  (measured_ms),
    .last         (last)
  );

endmodule

[sv/mmrd_checker.sv]
// Port-level checks for the meter response decoder, bound to the top level.
`include "assert_macros.svh"

module mmrd_checker import mmrd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [4:0]  value_index,
  input logic [31:0] value,
  input logic [31:0] measured_ms,
  input logic        last
);

  `MMRD_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(status) && $stable(value) && $stable(value_index) && $stable(last), "stalled result changed")
  `MMRD_ASSERT(a_single, result_valid && (status == ST_REJECT || status == ST_REQUEST) |-> last && value == 32'd0 && measured_ms == 32'd0 && value_index == 5'd0, "single result not clean")
  `MMRD_ASSERT(a_summary, result_valid && status == ST_SUMMARY |-> value_index <= LAST_SUMMARY && (last == (value_index == LAST_SUMMARY)), "summary index or last wrong")
  `MMRD_ASSERT(a_phase, result_valid && status == ST_PHASE |-> value_index <= LAST_PHASE && (last == (value_index == LAST_PHASE)), "phase index or last wrong")
  `MMRD_ASSERT_RST(a_reset, rst |=> !result_valid, "result valid after reset")

endmodule

bind modbus_meter_response_decoder mmrd_checker u_mmrd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .value_index  (value_index),
  .value        (value),
  .measured_ms  (measured_ms),
  .last         (last)
);
